>>> rtl/core/sibts_pkg.sv
// shared types and constants for the signed integer to base symbol converter
// no dependencies; imported by every module of the block
package sibts_pkg;

    localparam int SYM_W       = 8;
    localparam int NUM_SYMS    = 16;
    localparam int LEN_W       = 5;
    localparam int VALUE_PORT_W = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // configuration reset values: radix 10, symbols "0123456789"
    localparam logic [LEN_W-1:0]      BASE_LENGTH_RST  = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    // sign characters
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;

    typedef logic [SYM_W-1:0]          t_sym;
    typedef logic [NUM_SYMS*SYM_W-1:0] t_sym_table;
    typedef logic [3:0]                t_digit;

    // classification of one queued conversion
    typedef struct packed {
        logic base_invalid;
        logic neg;
    } t_job_ctl;

    // one result transfer
    typedef struct packed {
        logic valid;
        t_sym symbol;
        logic last;
        logic base_invalid;
    } t_result;

    // symbol byte for a digit value
    function automatic t_sym symbol_of(input t_sym_table tbl, input t_digit d);
        return tbl[d*SYM_W +: SYM_W];
    endfunction

endpackage

>>> rtl/core/sibts_front.sv
// front stage: takes a value, checks the base and forms sign and magnitude
// depends on sibts_pkg
module sibts_front #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [sibts_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic [sibts_pkg::LEN_W-1:0]      i_base_length,
    input  sibts_pkg::t_sym_table            i_sym_table,
    input  logic                             i_full,
    output logic                             o_push,
    output sibts_pkg::t_job_ctl              o_ctl,
    output logic [VALUE_WIDTH-1:0]           o_mag
);
    import sibts_pkg::*;

    logic                   r_valid;
    t_job_ctl               r_ctl;
    logic [VALUE_WIDTH-1:0] r_mag;
    t_job_ctl               n_ctl;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   base_ok;
    logic                   take;
    t_sym                   si;

    // base check: length range, forbidden symbols, duplicates among used symbols
    always_comb begin
        base_ok = (i_base_length >= LEN_W'(2)) && (i_base_length <= LEN_W'(MAX_SYMBOLS));
        si      = '0;
        for (int i = 0; i < NUM_SYMS; i++) begin
            si = symbol_of(i_sym_table, t_digit'(i));
            if (i < int'(i_base_length)) begin
                if (si == '0 || si == SIGN_MINUS || si == SIGN_PLUS) begin
                    base_ok = 1'b0;
                end
                for (int j = i + 1; j < NUM_SYMS; j++) begin
                    if (j < int'(i_base_length) && symbol_of(i_sym_table, t_digit'(j)) == si) begin
                        base_ok = 1'b0;
                    end
                end
            end
        end
    end

    // sign and magnitude of the low value bits
    assign raw                = i_value[VALUE_WIDTH-1:0];
    assign n_ctl.neg          = raw[VALUE_WIDTH-1];
    assign n_ctl.base_invalid = !base_ok;
    assign n_mag              = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

    // holding stage in front of the queue
    assign busy   = r_valid && i_full;
    assign take   = start && !busy;
    assign o_push = r_valid && !i_full;
    assign o_ctl  = r_ctl;
    assign o_mag  = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= take || (r_valid && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ctl <= n_ctl;
            r_mag <= n_mag;
        end
    end

endmodule

>>> rtl/core/sibts_queue.sv
// two-entry queue between the front and back stages
// depends on sibts_pkg
module sibts_queue #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  sibts_pkg::t_job_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  logic                   i_pop,
    output logic                   o_full,
    output logic                   o_empty,
    output sibts_pkg::t_job_ctl    o_ctl,
    output logic [VALUE_WIDTH-1:0] o_mag
);
    import sibts_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job_ctl               r_ctl_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_mag_mem [DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr;
    logic [PTR_W-1:0]       r_rd_ptr;
    logic [CNT_W-1:0]       r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_ctl   = r_ctl_mem[r_rd_ptr];
    assign o_mag   = r_mag_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ctl_mem[r_wr_ptr] <= i_ctl;
            r_mag_mem[r_wr_ptr] <= i_mag;
        end
    end

endmodule

>>> rtl/core/sibts_back.sv
// back stage: bit-serial division by the radix, digit stack, symbol output
// depends on sibts_pkg
module sibts_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  sibts_pkg::t_job_ctl         i_ctl,
    input  logic [VALUE_WIDTH-1:0]      i_mag,
    input  logic [sibts_pkg::LEN_W-1:0] i_radix,
    input  sibts_pkg::t_sym_table       i_sym_table,
    output sibts_pkg::t_result          o_result
);
    import sibts_pkg::*;

    localparam int BIT_W = $clog2(VALUE_WIDTH);
    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int ND_W  = $clog2(VALUE_WIDTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             r_state, n_state;
    logic                   r_neg, n_neg;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    t_digit                 r_rem, n_rem;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [ND_W-1:0]        r_nd, n_nd;
    t_result                r_result, n_result;
    t_digit                 r_digits [VALUE_WIDTH];

    logic [LEN_W-1:0]       trial;
    logic                   ge;
    t_digit                 rem_n;
    logic [VALUE_WIDTH-1:0] quot_n;
    logic                   dig_we;
    logic [IDX_W-1:0]       rd_idx;

    // one restoring division step
    assign trial  = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign ge     = (trial >= i_radix);
    assign rem_n  = ge ? t_digit'(trial - i_radix) : trial[3:0];
    assign quot_n = {r_quot[VALUE_WIDTH-2:0], ge};
    assign rd_idx = r_nd[IDX_W-1:0] - IDX_W'(1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_nd     = r_nd;
        n_result = '0;
        o_pop    = 1'b0;
        dig_we   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_ctl.base_invalid) begin
                        n_result.valid        = 1'b1;
                        n_result.symbol       = '0;
                        n_result.last         = 1'b1;
                        n_result.base_invalid = 1'b1;
                    end else begin
                        n_neg   = i_ctl.neg;
                        n_quot  = i_mag;
                        n_rem   = '0;
                        n_bit   = BIT_W'(VALUE_WIDTH - 1);
                        n_nd    = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_quot = quot_n;
                if (r_bit == '0) begin
                    // digit done: push remainder, restart on the quotient
                    dig_we = 1'b1;
                    n_nd   = r_nd + ND_W'(1);
                    n_rem  = '0;
                    n_bit  = BIT_W'(VALUE_WIDTH - 1);
                    if (quot_n == '0) begin
                        n_state = r_neg ? ST_SIGN : ST_EMIT;
                    end
                end else begin
                    n_rem = rem_n;
                    n_bit = r_bit - BIT_W'(1);
                end
            end
            ST_SIGN: begin
                n_result.valid        = 1'b1;
                n_result.symbol       = SIGN_MINUS;
                n_result.last         = 1'b0;
                n_result.base_invalid = 1'b0;
                n_state               = ST_EMIT;
            end
            ST_EMIT: begin
                // most significant digit sits on top of the stack
                n_result.valid        = 1'b1;
                n_result.symbol       = symbol_of(i_sym_table, r_digits[rd_idx]);
                n_result.last         = (r_nd == ND_W'(1));
                n_result.base_invalid = 1'b0;
                n_nd                  = r_nd - ND_W'(1);
                if (r_nd == ND_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_nd     <= '0;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_nd     <= n_nd;
            r_result <= n_result;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
    end

    // digit stack
    always_ff @(posedge i_clk) begin
        if (dig_we) begin
            r_digits[r_nd[IDX_W-1:0]] <= rem_n;
        end
    end

    assign o_result = r_result;

endmodule

>>> rtl/core/signed_integer_to_base_symbols.sv
// top level of the signed integer to base symbol converter
// depends on sibts_pkg, sibts_front, sibts_queue, sibts_back
//
// Usage:
//   A value is taken at a rising edge with start high and busy low. Each value
//   gives a stream of symbol bytes on o_symbol, one per cycle in which o_valid
//   is high: a minus sign for a negative value, then the digits of the
//   magnitude, most significant first, o_last marking the final byte. If the
//   configured base fails its check, one transfer with o_base_invalid and
//   o_last high and o_symbol zero is given instead.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data with
//   no wait. The user must write it only while no conversion is in flight;
//   the block itself does not enforce this. The back stage's bit-serial
//   divider produces one quotient bit per cycle and pushes the digits,
//   least significant first, onto a digit stack. A holding stage and a
//   two-entry queue take up to three further values while one is converted.
//   Reset clears the queue and the sequencer and restores radix 10 with the
//   symbols 0 to 9. The receiver cannot stall: each byte is shown once.
module signed_integer_to_base_symbols #(
    parameter int MAX_SYMBOLS = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sibts_pkg::VALUE_PORT_W-1:0]  i_value,
    input  logic                                i_cfg_we,
    input  logic [sibts_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sibts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                o_valid,
    output logic [sibts_pkg::SYM_W-1:0]         o_symbol,
    output logic                                o_last,
    output logic                                o_base_invalid
);
    import sibts_pkg::*;

    logic [LEN_W-1:0]       r_base_length;
    logic [CFG_DATA_W-1:0]  r_symbols_low;
    logic [CFG_DATA_W-1:0]  r_symbols_high;
    t_sym_table             sym_table;

    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    t_job_ctl               front_ctl;
    t_job_ctl               queue_ctl;
    logic [VALUE_WIDTH-1:0] front_mag;
    logic [VALUE_WIDTH-1:0] queue_mag;
    t_result                result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_length  <= BASE_LENGTH_RST;
            r_symbols_low  <= SYMBOLS_LOW_RST;
            r_symbols_high <= SYMBOLS_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BASE_LENGTH:  r_base_length  <= i_cfg_data[LEN_W-1:0];
                CFG_SYMBOLS_LOW:  r_symbols_low  <= i_cfg_data;
                CFG_SYMBOLS_HIGH: r_symbols_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sym_table = {r_symbols_high, r_symbols_low};

    // front: accept and classify
    sibts_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_base_length (r_base_length),
        .i_sym_table   (sym_table),
        .i_full        (q_full),
        .o_push        (push),
        .o_ctl         (front_ctl),
        .o_mag         (front_mag)
    );

    // queue between front and back
    sibts_queue #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (front_ctl),
        .i_mag   (front_mag),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_ctl   (queue_ctl),
        .o_mag   (queue_mag)
    );

    // back: divide and emit
    sibts_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_ctl       (queue_ctl),
        .i_mag       (queue_mag),
        .i_radix     (r_base_length),
        .i_sym_table (sym_table),
        .o_result    (result)
    );

    assign o_valid        = result.valid;
    assign o_symbol       = result.symbol;
    assign o_last         = result.last;
    assign o_base_invalid = result.base_invalid;

    // an invalid base gives a single zero byte that ends the conversion
    a_invalid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_base_invalid) |-> (o_last && o_symbol == '0))
        else $error("invalid-base transfer not a single zero byte");

    // a minus sign is never the final byte
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_base_invalid && o_symbol == SIGN_MINUS) |-> !o_last)
        else $error("minus sign marked last");

    // the first digit follows the minus sign in the next cycle
    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_base_invalid && o_symbol == SIGN_MINUS) |=>
        (o_valid && !o_base_invalid))
        else $error("no digit after minus sign");

endmodule

>>> dv/sibts_result_checker.sv
`timescale 1ns / 100ps
// result checker for the signed integer to base symbol converter
// depends on sibts_pkg; watches the value, configuration and symbol ports
module sibts_result_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_busy,
    input  logic [sibts_pkg::VALUE_PORT_W-1:0] i_value,
    input  logic                               i_cfg_we,
    input  logic [sibts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sibts_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_valid,
    input  logic [sibts_pkg::SYM_W-1:0]        i_symbol,
    input  logic                               i_last,
    input  logic                               i_base_invalid,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_errors
);
    import sibts_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_sym symbol;
        logic last;
        logic base_invalid;
    } t_symbol_xfer;

    // symbols still owed by the block, oldest first
    t_symbol_xfer pending_symbols[$];

    // shadow copy of the configuration registers
    logic [LEN_W-1:0]      radix_shadow;
    logic [CFG_DATA_W-1:0] sym_low;
    logic [CFG_DATA_W-1:0] sym_high;

    initial begin
        o_pending = 0;
        o_checked = 0;
        o_errors  = 0;
    end

    function automatic t_sym symbol_for(input int unsigned digit);
        logic [2*CFG_DATA_W-1:0] tbl;
        tbl = {sym_high, sym_low};
        return tbl[SYM_W*digit +: SYM_W];
    endfunction

    // radix in range, no null or sign symbol, no repeated symbol
    function automatic bit base_is_valid();
        int unsigned n;
        t_sym        s;
        if (radix_shadow < 2 || radix_shadow > NUM_SYMS)
            return 1'b0;
        n = radix_shadow;
        for (int unsigned i = 0; i < n; i++) begin
            s = symbol_for(i);
            if (s == '0 || s == SIGN_MINUS || s == SIGN_PLUS)
                return 1'b0;
            for (int unsigned j = i + 1; j < n; j++)
                if (symbol_for(j) == s)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void owe_symbol(input t_sym sym, input logic last, input logic inv);
        t_symbol_xfer x;
        x.symbol       = sym;
        x.last         = last;
        x.base_invalid = inv;
        pending_symbols.push_back(x);
    endfunction

    // text of one value: sign, then digits of the magnitude, msd first
    function automatic void predict_symbols(input logic [VALUE_PORT_W-1:0] v);
        logic [VALUE_PORT_W-1:0] mag;
        logic [VALUE_PORT_W-1:0] radix;
        logic [VALUE_PORT_W-1:0] rem;
        t_digit                  digits[VALUE_PORT_W+1];
        int                      nd;
        if (!base_is_valid()) begin
            owe_symbol('0, 1'b1, 1'b1);
            return;
        end
        radix = '0;
        radix[LEN_W-1:0] = radix_shadow;
        // two's complement negate also covers the most negative value
        mag = v[VALUE_PORT_W-1] ? (~v + 1'b1) : v;
        nd = 0;
        do begin
            rem = mag % radix;
            digits[nd] = rem[3:0];
            mag = mag / radix;
            nd++;
        end while (mag != 0);
        if (v[VALUE_PORT_W-1])
            owe_symbol(SIGN_MINUS, 1'b0, 1'b0);
        for (int i = nd - 1; i >= 0; i--)
            owe_symbol(symbol_for(digits[i]), i == 0, 1'b0);
    endfunction

    always @(posedge i_clk) begin : watch
        t_symbol_xfer want;
        if (!i_rst_n) begin
            radix_shadow = BASE_LENGTH_RST;
            sym_low      = SYMBOLS_LOW_RST;
            sym_high     = SYMBOLS_HIGH_RST;
            pending_symbols.delete();
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE_LENGTH:  radix_shadow = i_cfg_data[LEN_W-1:0];
                    CFG_SYMBOLS_LOW:  sym_low      = i_cfg_data;
                    CFG_SYMBOLS_HIGH: sym_high     = i_cfg_data;
                    default: ;
                endcase
            end
            // value transfer
            if (i_start === 1'b1 && i_busy === 1'b0)
                predict_symbols(i_value);
            // symbol transfer
            if (i_valid === 1'b1) begin
                o_checked++;
                if (pending_symbols.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_LIMIT)
                        $display("[%0t] unexpected symbol: sym=%h last=%b inv=%b",
                                 $realtime, i_symbol, i_last, i_base_invalid);
                end else begin
                    want = pending_symbols.pop_front();
                    if ({i_symbol, i_last, i_base_invalid} !== want) begin
                        o_errors++;
                        if (o_errors <= REPORT_LIMIT)
                            $display({"[%0t] symbol mismatch: exp sym=%h last=%b inv=%b",
                                      ", got sym=%h last=%b inv=%b"},
                                     $realtime, want.symbol, want.last, want.base_invalid,
                                     i_symbol, i_last, i_base_invalid);
                    end
                end
            end
        end
        o_pending = pending_symbols.size();
    end

endmodule

>>> dv/tb_signed_integer_to_base_symbols.sv
`timescale 1ns / 100ps
// testbench top for the signed integer to base symbol converter
// depends on sibts_pkg, the block and sibts_result_checker; makes stimulus and verdict
module tb_signed_integer_to_base_symbols;
    import sibts_pkg::*;

    localparam int RUN_LIMIT        = 1_500_000;
    localparam int TAIL_CYCLES      = 1200;
    localparam int RANDOM_PHASES    = 8;
    localparam int VALUES_PER_PHASE = 25;

    // the index past the last register, which the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h4645_4443_4241_3938;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic [VALUE_PORT_W-1:0] value_in    = '0;
    logic                    cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   cfg_data    = '0;
    logic                    o_valid;
    logic [SYM_W-1:0]        o_symbol;
    logic                    o_last;
    logic                    o_base_invalid;

    int               pending;
    int               checked;
    int               errors;
    int               values_sent  = 0;
    int               bases_loaded = 0;
    int               cycle_count  = 0;
    logic [LEN_W-1:0] radix_now    = BASE_LENGTH_RST;

    signed_integer_to_base_symbols uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (value_in),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_base_invalid (o_base_invalid)
    );

    sibts_result_checker result_watch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_value        (value_in),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (o_valid),
        .i_symbol       (o_symbol),
        .i_last         (o_last),
        .i_base_invalid (o_base_invalid),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_errors       (errors)
    );

    // 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d symbols still owed", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // hold the value until busy is low at a rising edge; start stays high
    task automatic send_value(input logic [VALUE_PORT_W-1:0] v);
        logic taken;
        start    <= 1'b1;
        value_in <= v;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = (busy === 1'b0);
            @(posedge i_clk);
        end
        values_sent++;
    endtask

    // random sender gap, each cycle idle with the given percentage
    task automatic idle_gap(input int pct);
        int n;
        n = 0;
        while ($urandom_range(0, 99) < pct)
            n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending until every owed symbol has been seen
    task automatic wait_all_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // full base setup: length word, then both symbol tables
    task automatic load_base(input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CFG_DATA_W-1:0] lo,
                             input logic [CFG_DATA_W-1:0] hi);
        wait_all_results();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_BASE_LENGTH, len_word);
        write_reg(CFG_SYMBOLS_LOW, lo);
        write_reg(CFG_SYMBOLS_HIGH, hi);
        radix_now = len_word[LEN_W-1:0];
        bases_loaded++;
    endtask

    // random base, mostly well formed with distinct printable-or-not symbols
    task automatic load_random_base();
        logic [2*CFG_DATA_W-1:0] tbl;
        logic [CFG_DATA_W-1:0]   len_word;
        bit                      used[256];
        int                      len;
        int                      b;
        int                      i;
        int                      j;
        tbl = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len = 2;
            1:       len = NUM_SYMS;
            default: len = $urandom_range(2, NUM_SYMS);
        endcase
        for (i = 0; i < len; i++) begin
            do
                b = $urandom_range(1, 255);
            while (b == SIGN_MINUS || b == SIGN_PLUS || used[b]);
            used[b] = 1'b1;
            tbl[SYM_W*i +: SYM_W] = b[SYM_W-1:0];
        end
        // now and then break the base
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: len = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(17, 31);
                1: begin
                    i = $urandom_range(0, len - 1);
                    case ($urandom_range(0, 2))
                        0:       tbl[SYM_W*i +: SYM_W] = '0;
                        1:       tbl[SYM_W*i +: SYM_W] = SIGN_MINUS;
                        default: tbl[SYM_W*i +: SYM_W] = SIGN_PLUS;
                    endcase
                end
                default: begin
                    i = $urandom_range(0, len - 1);
                    do
                        j = $urandom_range(0, len - 1);
                    while (j == i);
                    tbl[SYM_W*j +: SYM_W] = tbl[SYM_W*i +: SYM_W];
                end
            endcase
        end
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len[LEN_W-1:0];
        load_base(len_word, tbl[CFG_DATA_W-1:0], tbl[2*CFG_DATA_W-1:CFG_DATA_W]);
    endtask

    // value mix: full range, small, extremes, and radix powers around digit rollover
    function automatic logic [VALUE_PORT_W-1:0] random_value();
        longint p;
        longint v;
        longint r;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 40);
            1: v = -longint'($urandom_range(1, 40));
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 64'sh7FFF_FFFF - $urandom_range(0, 3);
                    1:       v = -64'sh8000_0000 + $urandom_range(0, 3);
                    default: v = $urandom_range(0, 1) ? 0 : -1;
                endcase
            end
            3: begin
                r = (radix_now < 2 || radix_now > NUM_SYMS) ? 10 : radix_now;
                p = 1;
                repeat ($urandom_range(1, 31))
                    if (p * r <= 64'sh8000_0000)
                        p = p * r;
                v = p - 1 + $urandom_range(0, 2);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            4: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom;
        endcase
        return v[VALUE_PORT_W-1:0];
    endfunction

    initial begin
        int pct;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // decimal after reset: zero, unit, extremes
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'd1_000_000_000);
        send_value(-32'sd999);

        // binary: longest outputs
        load_base(64'd2, 64'h3130, '0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd0);

        // full hex table
        load_base(64'd16, HEX_LOW, HEX_HIGH);
        send_value(32'hDEAD_BEEF);
        send_value(-32'sd1);

        // length word with upper data bits set, symbols at the byte extremes
        load_base(64'hFFFF_FFFF_FFFF_FFE3, 64'h0000_0000_0080_01FF, '1);
        send_value(-32'sd7);
        send_value(32'd12345);

        // broken bases: bad lengths, null and sign symbols, repeats
        load_base(64'd0, HEX_LOW, HEX_HIGH);
        send_value(32'd5);
        load_base(64'd1, HEX_LOW, HEX_HIGH);
        send_value(-32'sd5);
        load_base(64'd17, HEX_LOW, HEX_HIGH);
        send_value(32'd100);
        load_base(64'd31, HEX_LOW, HEX_HIGH);
        send_value(32'd100);
        load_base(64'd16, HEX_LOW, {SIGN_MINUS, HEX_HIGH[55:0]});
        send_value(-32'sd1);
        load_base(64'd10, {HEX_LOW[63:32], SIGN_PLUS, HEX_LOW[23:0]}, HEX_HIGH);
        send_value(32'd42);
        load_base(64'd10, '0, '0);
        send_value(32'd0);
        load_base(64'd16, {HEX_LOW[63:8], HEX_HIGH[63:56]}, HEX_HIGH);
        send_value(32'd77);
        load_base(64'd2, '1, '1);
        send_value(32'd1);

        // back to decimal; a write to the spare index must change nothing
        load_base({59'd0, BASE_LENGTH_RST}, SYMBOLS_LOW_RST, SYMBOLS_HIGH_RST);
        write_reg(CFG_SPARE_IDX, '1);
        send_value(32'd1_234_567_890);

        // random bases and values under several sender idling patterns
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 3)
                0:       pct = 0;
                1:       pct = 88;
                default: pct = 25;
            endcase
            load_random_base();
            for (int k = 0; k < VALUES_PER_PHASE; k++) begin
                send_value(random_value());
                idle_gap(pct);
                if ($urandom_range(0, 24) == 0)
                    wait_all_results();
            end
        end

        // drain and watch for stray symbols
        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("run covered %0d values over %0d base settings, %0d symbol transfers, %0d errors",
                 values_sent, bases_loaded, checked, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
